[rtl/kgc_pkg.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// kgc_pkg: shared types and constants for the knob gesture classifier
// Holds the configuration register map, the reset values of the registers,
// the button event codes and the configuration bundle passed between modules.
// ----------------------------------------------------------------------------
package kgc_pkg;

  localparam int TIME_BITS_DEF  = 32;
  localparam int COUNT_BITS_DEF = 32;

  localparam int CFG_ADDR_BITS = 5;
  localparam int CFG_DATA_BITS = 32;

  // Register indexes, each register sits at byte address 4*index.
  typedef enum logic [2:0] {
    REG_ROTATION_GUARD = 3'd0,
    REG_HOLD_THRESHOLD = 3'd1,
    REG_DOUBLE_WINDOW  = 3'd2,
    REG_MIN_CLICK      = 3'd3,
    REG_CW_INCREASES   = 3'd4
  } kgc_reg_t;

  localparam logic [15:0] ROTATION_GUARD_RST = 16'd100;
  localparam logic [15:0] HOLD_THRESHOLD_RST = 16'd500;
  localparam logic [15:0] DOUBLE_WINDOW_RST  = 16'd400;
  localparam logic [15:0] MIN_CLICK_RST      = 16'd50;
  localparam logic        CW_INCREASES_RST   = 1'b1;

  typedef enum logic [2:0] {
    EV_NONE         = 3'd0,
    EV_HOLD         = 3'd1,
    EV_HOLD_RELEASE = 3'd2,
    EV_DOUBLE       = 3'd3,
    EV_SINGLE       = 3'd4
  } kgc_event_t;

  typedef struct packed {
    logic [15:0] rotation_guard_ms;
    logic [15:0] hold_threshold_ms;
    logic [15:0] double_click_window_ms;
    logic [15:0] min_click_ms;
    logic        clockwise_increases;
  } kgc_cfg_t;

endpackage

[rtl/kgc_cfg_regs.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// kgc_cfg_regs: configuration register file
// APB-style slave with zero wait states. Writes land on the access phase,
// reads return the addressed register, unknown addresses read as zero.
// ----------------------------------------------------------------------------
module kgc_cfg_regs (
  input  logic                              clk,
  input  logic                              rst_n,
  input  logic                              psel,
  input  logic                              penable,
  input  logic                              pwrite,
  input  logic [kgc_pkg::CFG_ADDR_BITS-1:0] paddr,
  input  logic [kgc_pkg::CFG_DATA_BITS-1:0] pwdata,
  output logic [kgc_pkg::CFG_DATA_BITS-1:0] prdata,
  output logic                              pready,
  output kgc_pkg::kgc_cfg_t                 cfg
);
  import kgc_pkg::*;

  kgc_cfg_t cfg_r;
  kgc_cfg_t cfg_nxt;
  logic     wr_en;
  kgc_reg_t reg_idx;

  assign pready  = 1'b1;
  assign wr_en   = psel & penable & pwrite & pready;
  assign reg_idx = kgc_reg_t'(paddr[CFG_ADDR_BITS-1:2]);
  assign cfg     = cfg_r;

  always_comb begin
    cfg_nxt = cfg_r;
    if (wr_en) begin
      case (reg_idx)
        REG_ROTATION_GUARD: cfg_nxt.rotation_guard_ms      = pwdata[15:0];
        REG_HOLD_THRESHOLD: cfg_nxt.hold_threshold_ms      = pwdata[15:0];
        REG_DOUBLE_WINDOW:  cfg_nxt.double_click_window_ms = pwdata[15:0];
        REG_MIN_CLICK:      cfg_nxt.min_click_ms           = pwdata[15:0];
        REG_CW_INCREASES:   cfg_nxt.clockwise_increases    = pwdata[0];
        default:            cfg_nxt = cfg_r;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.rotation_guard_ms      <= ROTATION_GUARD_RST;
      cfg_r.hold_threshold_ms      <= HOLD_THRESHOLD_RST;
      cfg_r.double_click_window_ms <= DOUBLE_WINDOW_RST;
      cfg_r.min_click_ms           <= MIN_CLICK_RST;
      cfg_r.clockwise_increases    <= CW_INCREASES_RST;
    end else begin
      cfg_r <= cfg_nxt;
    end
  end

  always_comb begin
    case (reg_idx)
      REG_ROTATION_GUARD: prdata = CFG_DATA_BITS'(cfg_r.rotation_guard_ms);
      REG_HOLD_THRESHOLD: prdata = CFG_DATA_BITS'(cfg_r.hold_threshold_ms);
      REG_DOUBLE_WINDOW:  prdata = CFG_DATA_BITS'(cfg_r.double_click_window_ms);
      REG_MIN_CLICK:      prdata = CFG_DATA_BITS'(cfg_r.min_click_ms);
      REG_CW_INCREASES:   prdata = CFG_DATA_BITS'(cfg_r.clockwise_increases);
      default:            prdata = '0;
    endcase
  end

endmodule

[rtl/kgc_core.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// kgc_core: gesture state and per-poll classification
// Holds the knob state and computes the rotation delta and the button event
// of one poll combinationally; the state advances when step is high.
// ----------------------------------------------------------------------------
module kgc_core #(
  parameter int TIME_BITS  = kgc_pkg::TIME_BITS_DEF,
  parameter int COUNT_BITS = kgc_pkg::COUNT_BITS_DEF
) (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                step,
  input  kgc_pkg::kgc_cfg_t   cfg,
  input  logic [31:0]         time_ms,
  input  logic                button_down,
  input  logic                count_changed,
  input  logic signed [31:0]  encoder_count,
  output logic                delta_valid,
  output logic signed [31:0]  rotation_delta,
  output kgc_pkg::kgc_event_t button_event,
  output logic [31:0]         event_time
);
  import kgc_pkg::*;

  logic [COUNT_BITS-1:0] last_count_r, last_count_nxt;
  logic [TIME_BITS-1:0]  last_edge_r, last_edge_nxt;
  logic [TIME_BITS-1:0]  press_start_r, press_start_nxt;
  logic [TIME_BITS-1:0]  first_click_r, first_click_nxt;
  logic                  was_down_r, was_down_nxt;
  logic                  hold_fired_r, hold_fired_nxt;
  logic                  awaiting_r, awaiting_nxt;

  logic [TIME_BITS-1:0]  now;
  logic [COUNT_BITS-1:0] count;
  logic [COUNT_BITS-1:0] diff;
  logic [COUNT_BITS-1:0] delta;
  logic [TIME_BITS-1:0]  dur;
  logic                  dvalid;
  kgc_event_t            ev;

  // The count is sign-extended before it is cut to the internal width.
  assign now   = TIME_BITS'(time_ms);
  assign count = COUNT_BITS'(encoder_count);
  assign diff  = count - last_count_r;

  always_comb begin
    last_count_nxt  = last_count_r;
    last_edge_nxt   = last_edge_r;
    press_start_nxt = press_start_r;
    first_click_nxt = first_click_r;
    was_down_nxt    = was_down_r;
    hold_fired_nxt  = hold_fired_r;
    awaiting_nxt    = awaiting_r;
    dvalid          = 1'b0;
    delta           = '0;
    ev              = EV_NONE;
    dur             = now - press_start_r;

    // Rotation is judged against the edge time left by earlier polls.
    if (count_changed) begin
      last_count_nxt = count;
      if ((now - last_edge_r) > TIME_BITS'(cfg.rotation_guard_ms) && diff != '0) begin
        dvalid = 1'b1;
        delta  = cfg.clockwise_increases ? diff : -diff;
      end
    end

    if (button_down && !was_down_r) begin
      press_start_nxt = now;
      was_down_nxt    = 1'b1;
      hold_fired_nxt  = 1'b0;
      last_edge_nxt   = now;
    end

    if (button_down && was_down_nxt && !hold_fired_nxt) begin
      if ((now - press_start_nxt) >= TIME_BITS'(cfg.hold_threshold_ms)) begin
        hold_fired_nxt  = 1'b1;
        awaiting_nxt    = 1'b0;
        first_click_nxt = '0;
        ev              = EV_HOLD;
      end
    end

    if (!button_down && was_down_r) begin
      was_down_nxt  = 1'b0;
      last_edge_nxt = now;
      if (hold_fired_r) begin
        ev = EV_HOLD_RELEASE;
      end else if (dur >= TIME_BITS'(cfg.min_click_ms) &&
                   dur < TIME_BITS'(cfg.hold_threshold_ms)) begin
        if (awaiting_r &&
            (now - first_click_r) < TIME_BITS'(cfg.double_click_window_ms)) begin
          awaiting_nxt    = 1'b0;
          first_click_nxt = '0;
          ev              = EV_DOUBLE;
        end else begin
          awaiting_nxt    = 1'b1;
          first_click_nxt = now;
        end
      end
    end

    // A pending first click turns into a single click once the window ends.
    if (awaiting_nxt &&
        (now - first_click_nxt) >= TIME_BITS'(cfg.double_click_window_ms)) begin
      awaiting_nxt    = 1'b0;
      first_click_nxt = '0;
      ev              = EV_SINGLE;
    end
  end

  assign delta_valid    = dvalid;
  assign rotation_delta = 32'(delta);
  assign button_event   = ev;
  assign event_time     = (dvalid || ev != EV_NONE) ? 32'(now) : 32'd0;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      last_count_r  <= '0;
      last_edge_r   <= '0;
      press_start_r <= '0;
      first_click_r <= '0;
      was_down_r    <= 1'b0;
      hold_fired_r  <= 1'b0;
      awaiting_r    <= 1'b0;
    end else if (step) begin
      last_count_r  <= last_count_nxt;
      last_edge_r   <= last_edge_nxt;
      press_start_r <= press_start_nxt;
      first_click_r <= first_click_nxt;
      was_down_r    <= was_down_nxt;
      hold_fired_r  <= hold_fired_nxt;
      awaiting_r    <= awaiting_nxt;
    end
  end

endmodule

[rtl/knob_gesture_classifier.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// knob_gesture_classifier: rotary knob rotation and button gesture detector
// Pipeline: an item accepted on in_tdata passes two register stages (input
// register, result register) before its result appears on out_tdata.
// Throughput: one item per cycle; a stalled result holds the input stage.
// Reset (rst_n, synchronous, active low): registers to defaults, state and
// valid flags cleared.
// ----------------------------------------------------------------------------
module knob_gesture_classifier #(
  parameter int TIME_BITS  = kgc_pkg::TIME_BITS_DEF,
  parameter int COUNT_BITS = kgc_pkg::COUNT_BITS_DEF
) (
  input  logic                              clk,
  input  logic                              rst_n,
  // time_ms[31:0], button_down[32], count_changed[33], encoder_count[65:34]
  input  logic [71:0]                       in_tdata,
  input  logic                              in_tvalid,
  output logic                              in_tready,
  // delta_valid[0], rotation_delta[32:1], button_event[35:33], event_time[67:36]
  output logic [71:0]                       out_tdata,
  output logic                              out_tvalid,
  input  logic                              out_tready,
  input  logic                              psel,
  input  logic                              penable,
  input  logic                              pwrite,
  input  logic [kgc_pkg::CFG_ADDR_BITS-1:0] paddr,
  input  logic [kgc_pkg::CFG_DATA_BITS-1:0] pwdata,
  output logic [kgc_pkg::CFG_DATA_BITS-1:0] prdata,
  output logic                              pready
);
  import kgc_pkg::*;

  kgc_cfg_t          cfg;
  logic              in_valid_r;
  logic [65:0]       in_data_r;
  logic              out_valid_r;
  logic [67:0]       out_data_r;
  logic              advance;
  logic              step;
  logic              delta_valid;
  logic signed [31:0] rotation_delta;
  kgc_event_t        button_event;
  logic [31:0]       event_time;

  assign advance   = !out_valid_r || out_tready;
  assign step      = in_valid_r && advance;
  assign in_tready = !in_valid_r || advance;

  kgc_cfg_regs u_cfg (
    .clk     (clk),
    .rst_n   (rst_n),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready),
    .cfg     (cfg)
  );

  kgc_core #(
    .TIME_BITS  (TIME_BITS),
    .COUNT_BITS (COUNT_BITS)
  ) u_core (
    .clk            (clk),
    .rst_n          (rst_n),
    .step           (step),
    .cfg            (cfg),
    .time_ms        (in_data_r[31:0]),
    .button_down    (in_data_r[32]),
    .count_changed  (in_data_r[33]),
    .encoder_count  (signed'(in_data_r[65:34])),
    .delta_valid    (delta_valid),
    .rotation_delta (rotation_delta),
    .button_event   (button_event),
    .event_time     (event_time)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      in_valid_r  <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      if (in_tready) begin
        in_valid_r <= in_tvalid;
      end
      if (advance) begin
        out_valid_r <= in_valid_r;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (in_tready && in_tvalid) begin
      in_data_r <= in_tdata[65:0];
    end
    if (step) begin
      out_data_r <= {event_time, button_event, rotation_delta, delta_valid};
    end
  end

  assign out_tvalid = out_valid_r;
  assign out_tdata  = {4'd0, out_data_r};

endmodule

[verif/kgc_checker.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// kgc_checker: result checker for the knob gesture classifier
// Watches the poll, result and register channels, keeps its own copy of the
// classifier state and registers, works out the result of every accepted
// poll and compares each returned result field by field in order.
// ----------------------------------------------------------------------------
module kgc_checker (
  input  logic                              clk,
  input  logic                              rst_n,
  input  logic [71:0]                       in_tdata,
  input  logic                              in_tvalid,
  input  logic                              in_tready,
  input  logic [71:0]                       out_tdata,
  input  logic                              out_tvalid,
  input  logic                              out_tready,
  input  logic                              psel,
  input  logic                              penable,
  input  logic                              pwrite,
  input  logic [kgc_pkg::CFG_ADDR_BITS-1:0] paddr,
  input  logic [kgc_pkg::CFG_DATA_BITS-1:0] pwdata,
  input  logic                              pready,
  output int                                mismatch_count,
  output int                                polls_in_flight
);
  import kgc_pkg::*;

  typedef struct packed {
    logic        delta_valid;
    logic [31:0] rotation_delta;
    kgc_event_t  button_event;
    logic [31:0] event_time;
  } knob_result_t;

  knob_result_t expected_q[$];
  int           result_idx;

  // Register copy.
  logic [15:0] guard_ms;
  logic [15:0] hold_ms;
  logic [15:0] window_ms;
  logic [15:0] min_click_ms;
  logic        cw_increases;

  // Classifier state copy.
  logic [31:0] last_count;
  logic [31:0] last_edge_ms;
  logic [31:0] press_start_ms;
  logic        was_down;
  logic        hold_fired;
  logic        awaiting_second;
  logic [31:0] first_click_ms;

  task automatic report_mismatch(input string what, input logic [31:0] got,
                                 input logic [31:0] want);
    mismatch_count++;
    if (mismatch_count <= 40) begin
      $display("[%0t] result %0d: %s got %h wanted %h", $time, result_idx, what, got, want);
    end
  endtask

  task automatic classify_poll(input logic [31:0] now, input logic down, input logic moved,
                               input logic [31:0] cnt, output knob_result_t r);
    logic [31:0] elapsed;
    logic [31:0] diff;
    r = '0;
    r.button_event = EV_NONE;

    // Rotation looks at the edge time before this poll's button edges move it.
    if (moved) begin
      elapsed = now - last_edge_ms;
      if (elapsed > {16'd0, guard_ms}) begin
        diff = cnt - last_count;
        if (diff != 32'd0) begin
          r.delta_valid    = 1'b1;
          r.rotation_delta = cw_increases ? diff : 32'd0 - diff;
        end
      end
      last_count = cnt;
    end

    if (down && !was_down) begin
      press_start_ms = now;
      was_down       = 1'b1;
      hold_fired     = 1'b0;
      last_edge_ms   = now;
    end

    if (down && was_down && !hold_fired) begin
      elapsed = now - press_start_ms;
      if (elapsed >= {16'd0, hold_ms}) begin
        hold_fired      = 1'b1;
        awaiting_second = 1'b0;
        first_click_ms  = 32'd0;
        r.button_event  = EV_HOLD;
      end
    end

    if (!down && was_down) begin
      elapsed      = now - press_start_ms;
      was_down     = 1'b0;
      last_edge_ms = now;
      if (hold_fired) begin
        r.button_event = EV_HOLD_RELEASE;
      end else if (elapsed >= {16'd0, min_click_ms} && elapsed < {16'd0, hold_ms}) begin
        diff = now - first_click_ms;
        if (awaiting_second && diff < {16'd0, window_ms}) begin
          awaiting_second = 1'b0;
          first_click_ms  = 32'd0;
          r.button_event  = EV_DOUBLE;
        end else begin
          awaiting_second = 1'b1;
          first_click_ms  = now;
        end
      end
    end

    // A zero window lets a click just registered expire on the same poll.
    diff = now - first_click_ms;
    if (awaiting_second && diff >= {16'd0, window_ms}) begin
      awaiting_second = 1'b0;
      first_click_ms  = 32'd0;
      r.button_event  = EV_SINGLE;
    end

    r.event_time = (r.delta_valid || r.button_event != EV_NONE) ? now : 32'd0;
  endtask

  always @(posedge clk) begin
    knob_result_t want;
    knob_result_t got;
    if (!rst_n) begin
      mismatch_count  = 0;
      result_idx      = 0;
      guard_ms        = ROTATION_GUARD_RST;
      hold_ms         = HOLD_THRESHOLD_RST;
      window_ms       = DOUBLE_WINDOW_RST;
      min_click_ms    = MIN_CLICK_RST;
      cw_increases    = CW_INCREASES_RST;
      last_count      = 32'd0;
      last_edge_ms    = 32'd0;
      press_start_ms  = 32'd0;
      was_down        = 1'b0;
      hold_fired      = 1'b0;
      awaiting_second = 1'b0;
      first_click_ms  = 32'd0;
      expected_q.delete();
    end else begin
      if (psel && penable && pwrite && pready) begin
        case (kgc_reg_t'(paddr[4:2]))
          REG_ROTATION_GUARD: guard_ms     = pwdata[15:0];
          REG_HOLD_THRESHOLD: hold_ms      = pwdata[15:0];
          REG_DOUBLE_WINDOW:  window_ms    = pwdata[15:0];
          REG_MIN_CLICK:      min_click_ms = pwdata[15:0];
          REG_CW_INCREASES:   cw_increases = pwdata[0];
          default: ;
        endcase
      end

      if (in_tvalid && in_tready) begin
        classify_poll(in_tdata[31:0], in_tdata[32], in_tdata[33], in_tdata[65:34], want);
        expected_q.push_back(want);
      end

      if (out_tvalid && out_tready) begin
        got.delta_valid    = out_tdata[0];
        got.rotation_delta = out_tdata[32:1];
        got.button_event   = kgc_event_t'(out_tdata[35:33]);
        got.event_time     = out_tdata[67:36];
        if (expected_q.size() == 0) begin
          report_mismatch("result with nothing pending", out_tdata[31:0], 32'd0);
        end else begin
          want = expected_q.pop_front();
          if (got.delta_valid !== want.delta_valid)
            report_mismatch("delta_valid", {31'd0, got.delta_valid}, {31'd0, want.delta_valid});
          if (got.rotation_delta !== want.rotation_delta)
            report_mismatch("rotation_delta", got.rotation_delta, want.rotation_delta);
          if (got.button_event !== want.button_event)
            report_mismatch("button_event", {29'd0, got.button_event},
                            {29'd0, want.button_event});
          if (got.event_time !== want.event_time)
            report_mismatch("event_time", got.event_time, want.event_time);
        end
        result_idx++;
      end
    end
    polls_in_flight = expected_q.size();
  end

endmodule

[verif/tb.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb: regression bench for the knob gesture classifier
// Drives directed and random knob polls through several register settings,
// with random gaps on the poll side and random back-pressure on the result
// side; the checker predicts and compares every result.
// ----------------------------------------------------------------------------
module tb;
  import kgc_pkg::*;

  localparam int IDLE_LIMIT   = 2000;
  localparam int PHASE_POLLS  = 310;

  logic                     clk = 1'b0;
  logic                     rst_n;
  logic [71:0]              in_tdata;
  logic                     in_tvalid;
  logic                     in_tready;
  logic [71:0]              out_tdata;
  logic                     out_tvalid;
  logic                     out_tready;
  logic                     psel;
  logic                     penable;
  logic                     pwrite;
  logic [CFG_ADDR_BITS-1:0] paddr;
  logic [CFG_DATA_BITS-1:0] pwdata;
  logic [CFG_DATA_BITS-1:0] prdata;
  logic                     pready;

  int mismatch_count;
  int polls_in_flight;
  int idle_cycles = 0;

  bit gaps_on   = 1'b1;
  bit stalls_on = 1'b1;

  logic [31:0] now_ms;
  logic        button_level;
  logic [31:0] enc_count;

  always #5 clk = ~clk;

  knob_gesture_classifier i_dut (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_tdata  (in_tdata),
    .in_tvalid (in_tvalid),
    .in_tready (in_tready),
    .out_tdata (out_tdata),
    .out_tvalid(out_tvalid),
    .out_tready(out_tready),
    .psel      (psel),
    .penable   (penable),
    .pwrite    (pwrite),
    .paddr     (paddr),
    .pwdata    (pwdata),
    .prdata    (prdata),
    .pready    (pready)
  );

  kgc_checker i_checker (
    .clk            (clk),
    .rst_n          (rst_n),
    .in_tdata       (in_tdata),
    .in_tvalid      (in_tvalid),
    .in_tready      (in_tready),
    .out_tdata      (out_tdata),
    .out_tvalid     (out_tvalid),
    .out_tready     (out_tready),
    .psel           (psel),
    .penable        (penable),
    .pwrite         (pwrite),
    .paddr          (paddr),
    .pwdata         (pwdata),
    .pready         (pready),
    .mismatch_count (mismatch_count),
    .polls_in_flight(polls_in_flight)
  );

  // Cycles in which neither channel moves an item; a hang ends the run.
  always @(posedge clk) begin
    if (rst_n) begin
      if ((in_tvalid && in_tready) || (out_tvalid && out_tready)) begin
        idle_cycles <= 0;
      end else if (idle_cycles >= IDLE_LIMIT) begin
        $display("Regression FAIL");
        $finish;
      end else begin
        idle_cycles <= idle_cycles + 1;
      end
    end
  end

  // Result side: random back-pressure before each item.
  initial begin
    int stall;
    out_tready <= 1'b0;
    do @(posedge clk); while (!rst_n);
    forever begin
      stall = stalls_on ? $urandom_range(0, 13) : 0;
      if (stall > 0) begin
        out_tready <= 1'b0;
        repeat (stall) @(posedge clk);
      end
      out_tready <= 1'b1;
      do @(posedge clk); while (!out_tvalid);
    end
  end

  // Returns at the edge that accepts the item, with in_tvalid still high.
  task automatic send_poll(input logic [31:0] t, input logic down, input logic moved,
                           input logic [31:0] cnt);
    int gap;
    gap = gaps_on ? $urandom_range(0, 13) : 0;
    if (gap > 0) begin
      in_tvalid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_tdata  <= {6'd0, cnt, moved, down, t};
    in_tvalid <= 1'b1;
    do @(posedge clk); while (!in_tready);
  endtask

  task automatic drain(input int settle);
    in_tvalid <= 1'b0;
    do @(posedge clk); while (polls_in_flight != 0);
    repeat (settle) @(posedge clk);
  endtask

  task automatic cfg_write(input kgc_reg_t idx, input logic [31:0] value);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= {idx, 2'b00};
    pwdata  <= value;
    @(posedge clk);
    penable <= 1'b1;
    do @(posedge clk); while (!pready);
  endtask

  task automatic configure_all(input logic [15:0] guard, input logic [15:0] hold,
                               input logic [15:0] window, input logic [15:0] min_click,
                               input logic cw);
    drain(4);
    cfg_write(REG_ROTATION_GUARD, {16'd0, guard});
    cfg_write(REG_HOLD_THRESHOLD, {16'd0, hold});
    cfg_write(REG_DOUBLE_WINDOW, {16'd0, window});
    cfg_write(REG_MIN_CLICK, {16'd0, min_click});
    cfg_write(REG_CW_INCREASES, {31'd0, cw});
    psel    <= 1'b0;
    penable <= 1'b0;
    pwrite  <= 1'b0;
  endtask

  // Mostly coherent gesture streams: time moves forward on the scale of the
  // thresholds, the button toggles often, the count drifts by small steps.
  task automatic random_polls(input int n);
    int pick;
    logic moved;
    logic [31:0] field_count;
    for (int i = 0; i < n; i++) begin
      if (i % 40 == 0) begin
        gaps_on   = $urandom_range(0, 2) != 0;
        stalls_on = $urandom_range(0, 2) != 0;
      end
      pick = $urandom_range(0, 99);
      if (pick < 55)      now_ms += $urandom_range(0, 150);
      else if (pick < 88) now_ms += $urandom_range(0, 700);
      else if (pick < 97) now_ms += $urandom_range(0, 70000);
      else                now_ms += $urandom;
      if ($urandom_range(0, 99) < 40) button_level = ~button_level;
      moved = 1'($urandom_range(0, 1));
      if (moved) begin
        if ($urandom_range(0, 9) != 0) enc_count += $urandom_range(0, 10) - 5;
        else                           enc_count = $urandom;
      end
      // The count field is ignored without the changed flag, so noise it now and then.
      field_count = (!moved && $urandom_range(0, 7) == 0) ? $urandom : enc_count;
      send_poll(now_ms, button_level, moved, field_count);
    end
  endtask

  initial begin
    rst_n        <= 1'b0;
    in_tvalid    <= 1'b0;
    in_tdata     <= '0;
    psel         <= 1'b0;
    penable      <= 1'b0;
    pwrite       <= 1'b0;
    paddr        <= '0;
    pwdata       <= '0;
    now_ms       = 32'd0;
    button_level = 1'b0;
    enc_count    = 32'd0;
    repeat (8) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // Directed polls under the reset register values.
    send_poll(32'd200, 1'b0, 1'b1, 32'd5);
    send_poll(32'd210, 1'b0, 1'b1, 32'd5);                 // flag set, count unchanged
    send_poll(32'd220, 1'b0, 1'b1, 32'h7FFF_FFFF);
    send_poll(32'd230, 1'b0, 1'b1, 32'h8000_0000);         // count wraps
    send_poll(32'd1000, 1'b1, 1'b1, 32'h8000_0010);        // rotation before the press edge
    send_poll(32'd1050, 1'b1, 1'b1, 32'h8000_0020);        // inside guard, resync only
    send_poll(32'd1100, 1'b0, 1'b0, 32'd0);
    send_poll(32'd1200, 1'b0, 1'b1, 32'h8000_0021);        // exactly at the guard
    send_poll(32'd1201, 1'b0, 1'b1, 32'h8000_0022);
    send_poll(32'd1500, 1'b0, 1'b0, 32'd0);                // window runs out: single
    send_poll(32'd2000, 1'b1, 1'b0, 32'd0);
    send_poll(32'd2100, 1'b0, 1'b0, 32'd0);
    send_poll(32'd2200, 1'b1, 1'b0, 32'd0);
    send_poll(32'd2250, 1'b0, 1'b0, 32'd0);                // double, minimum length
    send_poll(32'd3000, 1'b1, 1'b0, 32'd0);
    send_poll(32'd3049, 1'b0, 1'b0, 32'd0);                // too short
    send_poll(32'd4000, 1'b1, 1'b0, 32'd0);
    send_poll(32'd4100, 1'b0, 1'b0, 32'd0);
    send_poll(32'd4200, 1'b1, 1'b0, 32'd0);
    send_poll(32'd4700, 1'b1, 1'b0, 32'd0);                // hold drops the pending click
    send_poll(32'd4800, 1'b0, 1'b0, 32'd0);
    send_poll(32'd5000, 1'b1, 1'b0, 32'd0);
    send_poll(32'd5600, 1'b0, 1'b0, 32'd0);                // long press, hold never seen
    send_poll(32'hFFFF_FFFF, 1'b1, 1'b0, 32'hFFFF_FFFF);
    send_poll(32'h0000_005F, 1'b0, 1'b0, 32'd0);           // press spans the time wrap
    send_poll(32'h0000_0200, 1'b0, 1'b0, 32'd0);
    now_ms = 32'h0000_0200;
    random_polls(PHASE_POLLS);

    configure_all(16'd0, 16'hFFFF, 16'hFFFF, 16'd0, 1'b0);
    random_polls(PHASE_POLLS);
    configure_all(16'hFFFF, 16'd0, 16'd0, 16'hFFFF, 1'b1);
    random_polls(PHASE_POLLS);
    configure_all(16'd16, 16'd300, 16'd0, 16'd20, 1'b0);
    random_polls(PHASE_POLLS);
    for (int p = 0; p < 2; p++) begin
      configure_all(16'($urandom_range(0, 300)), 16'($urandom_range(100, 1000)),
                    16'($urandom_range(0, 600)), 16'($urandom_range(0, 100)),
                    1'($urandom_range(0, 1)));
      random_polls(PHASE_POLLS);
    end

    drain(10);
    if (mismatch_count == 0) begin
      $display("Regression PASS");
    end else begin
      $display("Regression FAIL");
    end
    $finish;
  end

endmodule

[sim.f]
rtl/kgc_pkg.sv
rtl/kgc_cfg_regs.sv
rtl/kgc_core.sv
rtl/knob_gesture_classifier.sv
verif/kgc_checker.sv
verif/tb.sv
